// ===== rtl/ttf_pkg.sv =====
// Shared constants, sequencer state type and fixed-point helpers for the
// triangle tangent frame block. Depends on nothing; every other file imports it.
package ttf_pkg;

	localparam int POS_W   = 32;            // vertex position, Q16.16
	localparam int TEX_W   = 24;            // texture coordinate, Q8.16
	localparam int UNIT_W  = 16;            // normals, tangents, bitangents
	localparam int FRAC_W  = UNIT_W - 2;    // fraction bits of unit values
	localparam int EDGE_W  = POS_W + 1;     // position difference
	localparam int DUV_W   = TEX_W + 1;     // texture coordinate difference
	localparam int MUL_A_W = 36;            // shared multiplier, first operand
	localparam int MUL_B_W = EDGE_W;        // shared multiplier, second operand
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 64;            // accumulator
	localparam int VEC_W   = 60;            // vector under block scaling
	localparam int T_W     = 32;            // block scaled vector component
	localparam int K_W     = 6;             // shift count
	localparam int SQ_W    = 64;            // square root operands
	localparam int DIV_W   = 47;            // divider remainder and divisor
	localparam int QT_W    = 16;            // quotient bits per component
	localparam int QSTEP_W = 4;

	localparam logic [VEC_W-1:0] SCALE_LO = VEC_W'(1) << 29;
	localparam logic [VEC_W-1:0] SCALE_HI = VEC_W'(1) << 30;
	localparam logic [SQ_W-1:0]  ROOT_BIT0 = SQ_W'(1) << 62;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DET,
		ST_WDIR,
		ST_SC_MAX,
		ST_SC_SRCH,
		ST_SC_APPLY,
		ST_DOT,
		ST_DSCL,
		ST_SUB,
		ST_SQ,
		ST_SQRT,
		ST_DIV,
		ST_CROSS,
		ST_OUT
	} ttf_state_t;

	// Round half up, then arithmetic shift right; identity for a zero shift
	function automatic logic signed [ACC_W-1:0] rshr(input logic signed [ACC_W-1:0] x,
			input logic [K_W-1:0] s);
		logic signed [ACC_W-1:0] y;
		y = x + $signed(ACC_W'(1) << (s - K_W'(1)));
		if (s == '0) begin
			return x;
		end
		return y >>> s;
	endfunction

	// Clamp to the signed unit range
	function automatic logic signed [UNIT_W-1:0] sat_unit(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = $signed((ACC_W'(1) << (UNIT_W - 1)) - ACC_W'(1));
		lo = -$signed(ACC_W'(1) << (UNIT_W - 1));
		if (x > hi) begin
			return hi[UNIT_W-1:0];
		end
		if (x < lo) begin
			return lo[UNIT_W-1:0];
		end
		return x[UNIT_W-1:0];
	endfunction

endpackage

// ===== rtl/ttf_if.sv =====
// Valid/ready channels of the triangle tangent frame block: vertex items in,
// frame items out. Depends on ttf_pkg for the field widths.
interface ttf_vtx_if import ttf_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [POS_W-1:0]  pos_z;
	logic signed [TEX_W-1:0]  tex_u;
	logic signed [TEX_W-1:0]  tex_v;
	logic signed [UNIT_W-1:0] norm_x;
	logic signed [UNIT_W-1:0] norm_y;
	logic signed [UNIT_W-1:0] norm_z;

	modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
		input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
		output ready);
endinterface

interface ttf_frm_if import ttf_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [UNIT_W-1:0] tan_x;
	logic signed [UNIT_W-1:0] tan_y;
	logic signed [UNIT_W-1:0] tan_z;
	logic signed [UNIT_W-1:0] bitan_x;
	logic signed [UNIT_W-1:0] bitan_y;
	logic signed [UNIT_W-1:0] bitan_z;
	logic                     degenerate;
	logic                     last_of_triangle;

	modport source(output valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z, degenerate,
		last_of_triangle, input ready);
	modport sink(input valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z, degenerate,
		last_of_triangle, output ready);
endinterface

// ===== rtl/triangle_tangent_frame.sv =====
// Triangle tangent frame generator: top level, sequencer and shared datapath.
// Depends on ttf_pkg and the channel interfaces in ttf_if.sv.
//
// Vertices arrive one item at a time; every three form a triangle. The first
// two of a triangle are taken as they arrive and held. The third starts the
// frame computation, during which vertex.ready stays low; the three frame
// items then leave in arrival order, the third with last_of_triangle set.
// All products go through one 36x33 multiplier whose product is registered
// before use, and normalisation runs on shift and shift/subtract loops: the
// block scaling search, the square root and the three tangent divisions.
// A triangle with a zero texture determinant skips these loops and goes
// straight to its output handshakes. A result with zero tangent and
// bitangent and degenerate set marks a triangle whose tangent direction is
// undefined, or a vertex whose normal is parallel to it.
module triangle_tangent_frame import ttf_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	ttf_vtx_if.sink vertex,
	ttf_frm_if.source frame
);

	ttf_state_t state_q, state_d;
	logic [1:0] cnt_q;
	logic [1:0] cidx;
	logic       in_acc;
	logic       out_acc;

	// held corners
	logic signed [POS_W-1:0]  pos_q [3][3];
	logic signed [TEX_W-1:0]  tex_q [3][2];
	logic signed [UNIT_W-1:0] nrm_q [3][3];

	// triangle set-up
	logic signed [EDGE_W-1:0] e0_q [3];
	logic signed [EDGE_W-1:0] e1_q [3];
	logic signed [DUV_W-1:0]  du0_q, dv0_q, du1_q, dv1_q;
	logic det_neg_q, det_nz_q, ok_q;

	// shared arithmetic
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p, prod_q;
	logic signed [ACC_W-1:0]   acc_q, prod_lo, sum_v, diff_v, wneg, acc_n;
	logic signed [ACC_W-1:0]   dscl_v, sub_sh, crs_sh;
	logic [2:0] idx_q;
	logic       ph_q;
	logic [1:0] i3, i6;

	// block scaling
	logic signed [VEC_W-1:0] sv_q [3];
	logic [VEC_W-1:0]        mg [3];
	logic [VEC_W-1:0]        m_max, m_q;
	logic signed [ACC_W-1:0] sc_dn [3];
	logic signed [VEC_W-1:0] sc_val [3];
	logic [K_W-1:0]          k_q;
	logic                    up_q, sc_u_q, srch_done;

	// per vertex
	logic signed [UNIT_W-1:0]  nv [3];
	logic signed [T_W-1:0]     t_q [3];
	logic signed [MUL_A_W-1:0] d_q;
	logic signed [T_W-1:0]     u32;
	logic [1:0]                vtx_q;

	// root and division
	logic [SQ_W-1:0]    s_q, r_q, bit_q, trial;
	logic [DIV_W-1:0]   rem_q, dsr_q, dvd0;
	logic [QSTEP_W-1:0] dstep_q;
	logic [QT_W-1:0]    qt_q, q_new;
	logic               div_hit;

	// outputs
	logic signed [UNIT_W-1:0] tan_q [3];
	logic signed [UNIT_W-1:0] bitan_q [3];
	logic                     degen_q;

	function automatic logic [VEC_W-1:0] vmag(input logic signed [VEC_W-1:0] x);
		return x[VEC_W-1] ? $unsigned(-x) : $unsigned(x);
	endfunction

	assign in_acc  = vertex.valid && vertex.ready;
	assign out_acc = frame.valid && frame.ready;
	assign cidx    = cnt_q[1] ? 2'd2 : cnt_q;
	assign i3      = idx_q[1:0];
	assign i6      = idx_q[2:1];

	// select this vertex's normal
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nv[i] = nrm_q[vtx_q][i];
		end
	end

	// route operands to the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		u32   = $signed(sv_q[i3][T_W-1:0]);
		case (state_q)
			ST_DET: begin
				mul_a = idx_q[0] ? MUL_A_W'(du1_q) : MUL_A_W'(du0_q);
				mul_b = idx_q[0] ? MUL_B_W'(dv0_q) : MUL_B_W'(dv1_q);
			end
			ST_WDIR: begin
				mul_a = idx_q[0] ? MUL_A_W'(dv0_q) : MUL_A_W'(dv1_q);
				mul_b = idx_q[0] ? MUL_B_W'(e1_q[i6]) : MUL_B_W'(e0_q[i6]);
			end
			ST_DOT: begin
				mul_a = MUL_A_W'(nv[i3]);
				mul_b = MUL_B_W'(t_q[i3]);
			end
			ST_SUB: begin
				mul_a = d_q;
				mul_b = MUL_B_W'(nv[i3]);
			end
			ST_SQ: begin
				mul_a = MUL_A_W'(u32);
				mul_b = MUL_B_W'(u32);
			end
			ST_CROSS: begin
				case (i6)
					2'd0: begin
						mul_a = idx_q[0] ? MUL_A_W'(nv[2]) : MUL_A_W'(nv[1]);
						mul_b = idx_q[0] ? MUL_B_W'(tan_q[1]) : MUL_B_W'(tan_q[2]);
					end
					2'd1: begin
						mul_a = idx_q[0] ? MUL_A_W'(nv[0]) : MUL_A_W'(nv[2]);
						mul_b = idx_q[0] ? MUL_B_W'(tan_q[2]) : MUL_B_W'(tan_q[0]);
					end
					default: begin
						mul_a = idx_q[0] ? MUL_A_W'(nv[1]) : MUL_A_W'(nv[0]);
						mul_b = idx_q[0] ? MUL_B_W'(tan_q[0]) : MUL_B_W'(tan_q[1]);
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// accumulate, round and compare around the registered product
	always_comb begin
		prod_lo = $signed(prod_q[ACC_W-1:0]);
		sum_v   = acc_q + prod_lo;
		diff_v  = acc_q - prod_lo;
		wneg    = det_neg_q ? -diff_v : diff_v;
		acc_n   = (idx_q == 3'd0) ? prod_lo : sum_v;
		dscl_v  = rshr(acc_q, K_W'(FRAC_W));
		sub_sh  = rshr(prod_lo, K_W'(FRAC_W));
		crs_sh  = rshr(diff_v, K_W'(FRAC_W));
		m_max   = '0;
		for (int i = 0; i < 3; i++) begin
			mg[i]     = vmag(sv_q[i]);
			sc_dn[i]  = rshr(ACC_W'(sv_q[i]), k_q);
			sc_val[i] = up_q ? (sv_q[i] <<< k_q) : sc_dn[i][VEC_W-1:0];
			if (mg[i] > m_max) begin
				m_max = mg[i];
			end
		end
		srch_done = up_q ? (m_q >= SCALE_LO) : (m_q < SCALE_HI);
		trial     = r_q + bit_q;
		dvd0      = (DIV_W'(mg[i3]) << FRAC_W) + DIV_W'(r_q[T_W-1:0] >> 1);
		div_hit   = rem_q >= dsr_q;
		q_new     = qt_q | (QT_W'(div_hit) << dstep_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && cnt_q[1]) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: state_d = ST_DET;
			ST_DET: begin
				if (ph_q && idx_q == 3'd1) begin
					state_d = ST_WDIR;
				end
			end
			ST_WDIR: begin
				if (ph_q && idx_q == 3'd5) begin
					state_d = det_nz_q ? ST_SC_MAX : ST_OUT;
				end
			end
			ST_SC_MAX: state_d = (m_max == '0) ? ST_OUT : ST_SC_SRCH;
			ST_SC_SRCH: begin
				if (srch_done) begin
					state_d = ST_SC_APPLY;
				end
			end
			ST_SC_APPLY: state_d = sc_u_q ? ST_SQ : ST_DOT;
			ST_DOT: begin
				if (ph_q && idx_q == 3'd2) begin
					state_d = ST_DSCL;
				end
			end
			ST_DSCL: state_d = ST_SUB;
			ST_SUB: begin
				if (ph_q && idx_q == 3'd2) begin
					state_d = ST_SC_MAX;
				end
			end
			ST_SQ: begin
				if (ph_q && idx_q == 3'd2) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (bit_q == SQ_W'(1)) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (ph_q && dstep_q == '0 && idx_q == 3'd2) begin
					state_d = ST_CROSS;
				end
			end
			ST_CROSS: begin
				if (ph_q && idx_q == 3'd5) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (frame.ready) begin
					if (vtx_q == 2'd2) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ok_q ? ST_DOT : ST_OUT;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// channel outputs
	always_comb begin
		vertex.ready           = (state_q == ST_IDLE);
		frame.valid            = (state_q == ST_OUT);
		frame.tan_x            = tan_q[0];
		frame.tan_y            = tan_q[1];
		frame.tan_z            = tan_q[2];
		frame.bitan_x          = bitan_q[0];
		frame.bitan_y          = bitan_q[1];
		frame.bitan_z          = bitan_q[2];
		frame.degenerate       = degen_q;
		frame.last_of_triangle = (vtx_q == 2'd2);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				cnt_q <= cnt_q[1] ? 2'd0 : cnt_q + 2'd1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					pos_q[cidx][0] <= vertex.pos_x;
					pos_q[cidx][1] <= vertex.pos_y;
					pos_q[cidx][2] <= vertex.pos_z;
					tex_q[cidx][0] <= vertex.tex_u;
					tex_q[cidx][1] <= vertex.tex_v;
					nrm_q[cidx][0] <= vertex.norm_x;
					nrm_q[cidx][1] <= vertex.norm_y;
					nrm_q[cidx][2] <= vertex.norm_z;
				end
			end
			ST_SETUP: begin
				for (int i = 0; i < 3; i++) begin
					e0_q[i] <= EDGE_W'(pos_q[1][i]) - EDGE_W'(pos_q[0][i]);
					e1_q[i] <= EDGE_W'(pos_q[2][i]) - EDGE_W'(pos_q[0][i]);
				end
				du0_q  <= DUV_W'(tex_q[1][0]) - DUV_W'(tex_q[0][0]);
				dv0_q  <= DUV_W'(tex_q[1][1]) - DUV_W'(tex_q[0][1]);
				du1_q  <= DUV_W'(tex_q[2][0]) - DUV_W'(tex_q[0][0]);
				dv1_q  <= DUV_W'(tex_q[2][1]) - DUV_W'(tex_q[0][1]);
				vtx_q  <= '0;
				sc_u_q <= 1'b0;
			end
			ST_DET, ST_WDIR, ST_DOT, ST_SUB, ST_SQ, ST_CROSS: begin
				if (!ph_q) begin
					prod_q <= mul_p;
					ph_q   <= 1'b1;
				end else begin
					if (state_d == state_q) begin
						ph_q  <= 1'b0;
						idx_q <= idx_q + 3'd1;
					end
					case (state_q)
						ST_DET: begin
							acc_q     <= prod_lo;
							det_neg_q <= diff_v[ACC_W-1];
							det_nz_q  <= (diff_v != '0);
						end
						ST_WDIR: begin
							if (!idx_q[0]) begin
								acc_q <= prod_lo;
							end else begin
								sv_q[i6] <= wneg[VEC_W-1:0];
							end
							if (idx_q == 3'd5) begin
								ok_q <= det_nz_q;
								if (!det_nz_q) begin
									for (int i = 0; i < 3; i++) begin
										tan_q[i]   <= '0;
										bitan_q[i] <= '0;
									end
									degen_q <= 1'b1;
								end
							end
						end
						ST_DOT: acc_q <= acc_n;
						ST_SUB: begin
							sv_q[i3] <= VEC_W'(t_q[i3]) - sub_sh[VEC_W-1:0];
							sc_u_q   <= 1'b1;
						end
						ST_SQ: begin
							acc_q <= acc_n;
							s_q   <= acc_n;
							r_q   <= '0;
							bit_q <= ROOT_BIT0;
						end
						ST_CROSS: begin
							if (!idx_q[0]) begin
								acc_q <= prod_lo;
							end else begin
								bitan_q[i6] <= sat_unit(crs_sh);
							end
							degen_q <= 1'b0;
						end
						default: acc_q <= acc_q;
					endcase
				end
			end
			ST_SC_MAX: begin
				m_q  <= m_max;
				k_q  <= '0;
				up_q <= (m_max < SCALE_LO);
				if (!sc_u_q) begin
					ok_q <= (m_max != '0);
				end
				if (m_max == '0) begin
					for (int i = 0; i < 3; i++) begin
						tan_q[i]   <= '0;
						bitan_q[i] <= '0;
					end
					degen_q <= 1'b1;
				end
			end
			ST_SC_SRCH: begin
				if (!srch_done) begin
					m_q <= up_q ? (m_q << 1) : (m_q >> 1);
					k_q <= k_q + K_W'(1);
				end
			end
			ST_SC_APPLY: begin
				for (int i = 0; i < 3; i++) begin
					sv_q[i] <= sc_val[i];
					if (!sc_u_q) begin
						t_q[i] <= sc_val[i][T_W-1:0];
					end
				end
			end
			ST_DSCL: d_q <= dscl_v[MUL_A_W-1:0];
			ST_SQRT: begin
				if (s_q >= trial) begin
					s_q <= s_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DIV: begin
				if (!ph_q) begin
					rem_q   <= dvd0;
					dsr_q   <= DIV_W'(r_q[T_W-1:0]) << (QT_W - 1);
					dstep_q <= QSTEP_W'(QT_W - 1);
					qt_q    <= '0;
					ph_q    <= 1'b1;
				end else begin
					if (div_hit) begin
						rem_q <= rem_q - dsr_q;
					end
					qt_q    <= q_new;
					dsr_q   <= dsr_q >> 1;
					dstep_q <= dstep_q - QSTEP_W'(1);
					if (dstep_q == '0) begin
						tan_q[i3] <= sv_q[i3][VEC_W-1] ? -$signed(q_new) : $signed(q_new);
						if (state_d == state_q) begin
							idx_q <= idx_q + 3'd1;
							ph_q  <= 1'b0;
						end
					end
				end
			end
			ST_OUT: begin
				if (out_acc) begin
					vtx_q  <= vtx_q + 2'd1;
					sc_u_q <= 1'b0;
				end
			end
			default: acc_q <= acc_q;
		endcase
		// restart the step counters on every state change
		if (state_d != state_q) begin
			idx_q <= '0;
			ph_q  <= 1'b0;
		end
	end

endmodule

// ===== rtl/ttf_checker.sv =====
// Port-level checks for the triangle tangent frame block, bound to its top
// level. Depends on ttf_pkg for the field widths.
module ttf_checker import ttf_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [UNIT_W-1:0] tan_x,
	input logic signed [UNIT_W-1:0] tan_y,
	input logic signed [UNIT_W-1:0] tan_z,
	input logic signed [UNIT_W-1:0] bitan_x,
	input logic signed [UNIT_W-1:0] bitan_y,
	input logic signed [UNIT_W-1:0] bitan_z,
	input logic                     degenerate,
	input logic                     last_of_triangle
);

	// hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tan_x) && $stable(tan_y)
			&& $stable(tan_z) && $stable(bitan_x) && $stable(bitan_y) && $stable(bitan_z)
			&& $stable(degenerate) && $stable(last_of_triangle))
		else $error("result item changed while stalled");

	// take no vertex while a result is shown
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("vertex taken while a result is pending");

	// degenerate results carry zero vectors
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> tan_x == '0 && tan_y == '0 && tan_z == '0
			&& bitan_x == '0 && bitan_y == '0 && bitan_z == '0)
		else $error("degenerate result with non-zero vectors");

	// a valid frame has a normalised, hence non-zero, tangent
	a_tan_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> tan_x != '0 || tan_y != '0 || tan_z != '0)
		else $error("zero tangent without degenerate flag");

	// return to taking vertices after the last result of a triangle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_of_triangle |=> in_ready)
		else $error("not ready for vertices after a triangle");

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(vertex.ready),
	.out_valid(frame.valid),
	.out_ready(frame.ready),
	.tan_x(frame.tan_x),
	.tan_y(frame.tan_y),
	.tan_z(frame.tan_z),
	.bitan_x(frame.bitan_x),
	.bitan_y(frame.bitan_y),
	.bitan_z(frame.bitan_z),
	.degenerate(frame.degenerate),
	.last_of_triangle(frame.last_of_triangle)
);
